FILE: src/rgbdl_pkg.sv
package rgbdl_pkg;

    // Field widths
    localparam int CFG_W     = 13;
    localparam int STRIDE_W  = 16;
    localparam int OFF_W     = 28;
    localparam int PIX_W     = 8;
    localparam int IDX_W     = 3;
    localparam int DIV_CNT_W = 4;

    // Register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_SRC_W  = 3'd0,
        REG_SRC_H  = 3'd1,
        REG_TGT_W  = 3'd2,
        REG_TGT_H  = 3'd3,
        REG_GRAY   = 3'd4,
        REG_STRIDE = 3'd5
    } reg_index_t;

    // Register reset values
    localparam logic [CFG_W-1:0]    RST_SRC_W  = 13'd640;
    localparam logic [CFG_W-1:0]    RST_SRC_H  = 13'd480;
    localparam logic [CFG_W-1:0]    RST_TGT_W  = 13'd640;
    localparam logic [CFG_W-1:0]    RST_TGT_H  = 13'd480;
    localparam logic [STRIDE_W-1:0] RST_STRIDE = 16'd0;

    // Luma weights, sum fits in 18 bits (255 * 1000)
    localparam int SUM_W = 18;
    localparam logic [SUM_W-1:0] LUMA_R = 18'd299;
    localparam logic [SUM_W-1:0] LUMA_G = 18'd587;
    localparam logic [SUM_W-1:0] LUMA_B = 18'd114;

    // Divide by 1000 as multiply by ceil(2^28 / 1000), exact for sums below 493447
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = 19'd268436;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = QPTR_W + 1;

    // Ratio derivation sequencer
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN,
        DIV_CHECK
    } div_state_t;

    // Derived settings seen by the front
    typedef struct packed {
        logic                busy;
        logic                clear;
        logic                sizes_ok;
        logic                gray;
        logic [CFG_W-1:0]    src_w;
        logic [CFG_W-1:0]    src_h;
        logic [CFG_W-1:0]    tgt_w;
        logic [CFG_W-1:0]    tgt_h;
        logic [CFG_W-1:0]    ratio_x;
        logic [CFG_W-1:0]    ratio_y;
        logic [STRIDE_W-1:0] stride;
    } setup_t;

    // One classified request travelling from front to back
    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             gray;
        logic             frame_end;
        logic             size_error;
    } pix_item_t;

endpackage

FILE: src/rgbdl_setup.sv
module rgbdl_setup #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [rgbdl_pkg::IDX_W-1:0]           cfg_index,
    input  logic [rgbdl_pkg::STRIDE_W-1:0]        cfg_data,
    output rgbdl_pkg::setup_t                     setup
);

    localparam int CFG_W = rgbdl_pkg::CFG_W;
    localparam int LIM_W = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
    localparam logic [LIM_W-1:0] LIMIT = LIM_W'(MAX_DIM);

    logic [CFG_W-1:0]              src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic                          gray_reg;
    logic [rgbdl_pkg::STRIDE_W-1:0] line_stride_reg;

    logic [CFG_W-1:0]              qx_reg, rx_reg, qy_reg, ry_reg;
    logic [rgbdl_pkg::DIV_CNT_W-1:0] step_reg;
    logic [CFG_W-1:0]              ratio_x_reg, ratio_y_reg;
    logic [rgbdl_pkg::STRIDE_W-1:0] stride_reg;
    logic                          ok_reg;

    rgbdl_pkg::div_state_t state_reg, state_next;

    logic cfg_hit;
    logic do_load, do_step, do_check, busy;
    logic [CFG_W:0] rx_sh, ry_sh;
    logic           x_fit, y_fit;
    logic           sizes_ok;
    logic [rgbdl_pkg::STRIDE_W-1:0] packed_stride;

    // Writes to an index beyond the list are dropped
    assign cfg_hit = cfg_write && (cfg_index <= rgbdl_pkg::REG_STRIDE);

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg       <= rgbdl_pkg::RST_SRC_W;
            src_h_reg       <= rgbdl_pkg::RST_SRC_H;
            tgt_w_reg       <= rgbdl_pkg::RST_TGT_W;
            tgt_h_reg       <= rgbdl_pkg::RST_TGT_H;
            gray_reg        <= 1'b0;
            line_stride_reg <= rgbdl_pkg::RST_STRIDE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rgbdl_pkg::REG_SRC_W:  src_w_reg       <= cfg_data[CFG_W-1:0];
                rgbdl_pkg::REG_SRC_H:  src_h_reg       <= cfg_data[CFG_W-1:0];
                rgbdl_pkg::REG_TGT_W:  tgt_w_reg       <= cfg_data[CFG_W-1:0];
                rgbdl_pkg::REG_TGT_H:  tgt_h_reg       <= cfg_data[CFG_W-1:0];
                rgbdl_pkg::REG_GRAY:   gray_reg        <= cfg_data[0];
                rgbdl_pkg::REG_STRIDE: line_stride_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer next state: any write to a listed register restarts the derivation
    always_comb
    begin
        state_next = state_reg;
        if (cfg_hit)
        begin
            state_next = rgbdl_pkg::DIV_LOAD;
        end
        else
        begin
            unique case (state_reg)
                rgbdl_pkg::DIV_IDLE:  state_next = rgbdl_pkg::DIV_IDLE;
                rgbdl_pkg::DIV_LOAD:  state_next = rgbdl_pkg::DIV_RUN;
                rgbdl_pkg::DIV_RUN:
                begin
                    if (step_reg == rgbdl_pkg::DIV_CNT_W'(CFG_W - 1))
                    begin
                        state_next = rgbdl_pkg::DIV_CHECK;
                    end
                end
                rgbdl_pkg::DIV_CHECK: state_next = rgbdl_pkg::DIV_IDLE;
                default:              state_next = rgbdl_pkg::DIV_LOAD;
            endcase
        end
    end

    // Sequencer outputs
    always_comb
    begin
        do_load  = 1'b0;
        do_step  = 1'b0;
        do_check = 1'b0;
        busy     = 1'b1;
        unique case (state_reg)
            rgbdl_pkg::DIV_IDLE:  busy     = 1'b0;
            rgbdl_pkg::DIV_LOAD:  do_load  = 1'b1;
            rgbdl_pkg::DIV_RUN:   do_step  = 1'b1;
            rgbdl_pkg::DIV_CHECK: do_check = 1'b1;
            default:              do_load  = 1'b1;
        endcase
    end

    // Start in the load state so reset values are derived as well
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgbdl_pkg::DIV_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One restoring step per cycle for each dimension
    assign rx_sh = {rx_reg, qx_reg[CFG_W-1]};
    assign ry_sh = {ry_reg, qy_reg[CFG_W-1]};
    assign x_fit = rx_sh >= {1'b0, tgt_w_reg};
    assign y_fit = ry_sh >= {1'b0, tgt_h_reg};

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            qx_reg   <= src_w_reg;
            rx_reg   <= '0;
            qy_reg   <= src_h_reg;
            ry_reg   <= '0;
            step_reg <= '0;
        end
        else if (do_step)
        begin
            qx_reg   <= {qx_reg[CFG_W-2:0], x_fit};
            rx_reg   <= x_fit ? CFG_W'(rx_sh - {1'b0, tgt_w_reg}) : rx_sh[CFG_W-1:0];
            qy_reg   <= {qy_reg[CFG_W-2:0], y_fit};
            ry_reg   <= y_fit ? CFG_W'(ry_sh - {1'b0, tgt_h_reg}) : ry_sh[CFG_W-1:0];
            step_reg <= step_reg + 1'b1;
        end
    end

    // Check sizes once quotients and remainders are final
    assign sizes_ok = (src_w_reg != '0) && (src_h_reg != '0) &&
                      (tgt_w_reg != '0) && (tgt_h_reg != '0) &&
                      (LIM_W'(src_w_reg) <= LIMIT) && (LIM_W'(src_h_reg) <= LIMIT) &&
                      (tgt_w_reg <= src_w_reg) && (tgt_h_reg <= src_h_reg) &&
                      (rx_reg == '0) && (ry_reg == '0);

    // Packed line length is target width times bytes per pixel
    assign packed_stride = gray_reg ?
        rgbdl_pkg::STRIDE_W'(tgt_w_reg) :
        rgbdl_pkg::STRIDE_W'(tgt_w_reg) + rgbdl_pkg::STRIDE_W'({tgt_w_reg, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg      <= 1'b0;
            ratio_x_reg <= CFG_W'(1);
            ratio_y_reg <= CFG_W'(1);
            stride_reg  <= '0;
        end
        else if (do_check)
        begin
            ok_reg      <= sizes_ok;
            ratio_x_reg <= sizes_ok ? qx_reg : CFG_W'(1);
            ratio_y_reg <= sizes_ok ? qy_reg : CFG_W'(1);
            stride_reg  <= (line_stride_reg != '0) ? line_stride_reg : packed_stride;
        end
    end

    assign setup.busy     = busy;
    assign setup.clear    = cfg_hit;
    assign setup.sizes_ok = ok_reg;
    assign setup.gray     = gray_reg;
    assign setup.src_w    = src_w_reg;
    assign setup.src_h    = src_h_reg;
    assign setup.tgt_w    = tgt_w_reg;
    assign setup.tgt_h    = tgt_h_reg;
    assign setup.ratio_x  = ratio_x_reg;
    assign setup.ratio_y  = ratio_y_reg;
    assign setup.stride   = stride_reg;

endmodule

FILE: src/rgbdl_front.sv
module rgbdl_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rgbdl_pkg::setup_t                 setup,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rgbdl_pkg::PIX_W-1:0]       red,
    input  logic [rgbdl_pkg::PIX_W-1:0]       green,
    input  logic [rgbdl_pkg::PIX_W-1:0]       blue,
    input  logic                              q_full,
    output logic                              push,
    output rgbdl_pkg::pix_item_t              push_item
);

    localparam int CFG_W = rgbdl_pkg::CFG_W;
    localparam int OFF_W = rgbdl_pkg::OFF_W;
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

    logic [CNT_W-1:0] col_reg, row_reg, cph_reg, rph_reg, ocol_reg, orow_reg;
    logic [CNT_W-1:0] col_next, row_next, cph_next, rph_next, ocol_next, orow_next;
    logic [OFF_W-1:0] off_reg, base_reg, off_next, base_next;

    logic [CMP_W-1:0] col_inc, row_inc, cph_inc, rph_inc, ocol_inc, orow_inc;
    logic             accept, keep, last;
    logic [1:0]       bpp;

    assign in_ready = !setup.busy && !setup.clear && !q_full;
    assign accept   = in_valid && in_ready;
    assign keep     = (cph_reg == '0) && (rph_reg == '0);
    assign bpp      = setup.gray ? 2'd1 : 2'd3;

    assign col_inc  = CMP_W'(col_reg) + 1'b1;
    assign row_inc  = CMP_W'(row_reg) + 1'b1;
    assign cph_inc  = CMP_W'(cph_reg) + 1'b1;
    assign rph_inc  = CMP_W'(rph_reg) + 1'b1;
    assign ocol_inc = CMP_W'(ocol_reg) + 1'b1;
    assign orow_inc = CMP_W'(orow_reg) + 1'b1;

    assign last = (ocol_inc == CMP_W'(setup.tgt_w)) && (orow_inc == CMP_W'(setup.tgt_h));

    // Classify: error request on bad sizes, pixel request when both phases are zero
    assign push = accept && (!setup.sizes_ok || keep);

    always_comb
    begin
        push_item.gray = setup.gray;
        if (!setup.sizes_ok)
        begin
            push_item.offset     = '0;
            push_item.red        = '0;
            push_item.green      = '0;
            push_item.blue       = '0;
            push_item.frame_end  = 1'b0;
            push_item.size_error = 1'b1;
        end
        else
        begin
            push_item.offset     = off_reg;
            push_item.red        = red;
            push_item.green      = green;
            push_item.blue       = blue;
            push_item.frame_end  = last;
            push_item.size_error = 1'b0;
        end
    end

    // Advance source and output counters
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        cph_next  = cph_reg;
        rph_next  = rph_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        off_next  = off_reg;
        base_next = base_reg;
        if (setup.clear)
        begin
            col_next  = '0;
            row_next  = '0;
            cph_next  = '0;
            rph_next  = '0;
            ocol_next = '0;
            orow_next = '0;
            off_next  = '0;
            base_next = '0;
        end
        else if (accept && setup.sizes_ok)
        begin
            // Output position and destination offset
            if (keep)
            begin
                if (ocol_inc >= CMP_W'(setup.tgt_w))
                begin
                    ocol_next = '0;
                    if (orow_inc >= CMP_W'(setup.tgt_h))
                    begin
                        orow_next = '0;
                        base_next = '0;
                        off_next  = '0;
                    end
                    else
                    begin
                        orow_next = orow_inc[CNT_W-1:0];
                        base_next = base_reg + OFF_W'(setup.stride);
                        off_next  = base_reg + OFF_W'(setup.stride);
                    end
                end
                else
                begin
                    ocol_next = ocol_inc[CNT_W-1:0];
                    off_next  = off_reg + OFF_W'(bpp);
                end
            end

            // Source position and phases
            if (col_inc >= CMP_W'(setup.src_w))
            begin
                col_next = '0;
                cph_next = '0;
                if (row_inc >= CMP_W'(setup.src_h))
                begin
                    row_next  = '0;
                    rph_next  = '0;
                    ocol_next = '0;
                    orow_next = '0;
                    off_next  = '0;
                    base_next = '0;
                end
                else
                begin
                    row_next = row_inc[CNT_W-1:0];
                    rph_next = (rph_inc >= CMP_W'(setup.ratio_y)) ? '0 : rph_inc[CNT_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
                cph_next = (cph_inc >= CMP_W'(setup.ratio_x)) ? '0 : cph_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cph_reg  <= '0;
            rph_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            off_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cph_reg  <= cph_next;
            rph_reg  <= rph_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            off_reg  <= off_next;
            base_reg <= base_next;
        end
    end

endmodule

FILE: src/rgbdl_queue.sv
module rgbdl_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rgbdl_pkg::pix_item_t  push_item,
    input  logic                  pop,
    output rgbdl_pkg::pix_item_t  head_item,
    output logic                  not_empty,
    output logic                  full
);

    rgbdl_pkg::pix_item_t slot_reg [rgbdl_pkg::QDEPTH];

    logic [rgbdl_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rgbdl_pkg::QCNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == rgbdl_pkg::QCNT_W'(rgbdl_pkg::QDEPTH));
    assign head_item = slot_reg[rd_ptr_reg];

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/rgbdl_back.sv
module rgbdl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rgbdl_pkg::pix_item_t          head_item,
    input  logic                          not_empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rgbdl_pkg::OFF_W-1:0]   byte_offset,
    output logic [rgbdl_pkg::PIX_W-1:0]   first_value,
    output logic [rgbdl_pkg::PIX_W-1:0]   second_value,
    output logic [rgbdl_pkg::PIX_W-1:0]   third_value,
    output logic                          frame_end,
    output logic                          size_error
);

    localparam int SUM_W  = rgbdl_pkg::SUM_W;
    localparam int PROD_W = rgbdl_pkg::PROD_W;
    localparam int PIX_W  = rgbdl_pkg::PIX_W;

    logic                  advance;
    logic                  s1_valid_reg, s2_valid_reg, out_valid_reg;
    rgbdl_pkg::pix_item_t  s1_item_reg, s2_item_reg;
    logic [SUM_W-1:0]      s1_sum_reg, sum;
    logic [PROD_W-1:0]     prod;
    logic [PIX_W-1:0]      s2_luma_reg;

    logic [rgbdl_pkg::OFF_W-1:0] offset_reg;
    logic [PIX_W-1:0]            first_reg, second_reg, third_reg;
    logic                        frame_end_reg, size_error_reg;

    // Move the whole pipe when the output register is free or being drained
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && not_empty;

    // Weighted channel sum
    assign sum = SUM_W'(head_item.red)   * rgbdl_pkg::LUMA_R +
                 SUM_W'(head_item.green) * rgbdl_pkg::LUMA_G +
                 SUM_W'(head_item.blue)  * rgbdl_pkg::LUMA_B;

    // Divide by 1000 through the reciprocal
    assign prod = PROD_W'(s1_sum_reg) * PROD_W'(rgbdl_pkg::RECIP_K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= not_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg <= head_item;
            s1_sum_reg  <= sum;
            s2_item_reg <= s1_item_reg;
            s2_luma_reg <= prod[rgbdl_pkg::RECIP_SHIFT +: PIX_W];

            offset_reg     <= s2_item_reg.offset;
            frame_end_reg  <= s2_item_reg.frame_end;
            size_error_reg <= s2_item_reg.size_error;
            if (s2_item_reg.size_error)
            begin
                first_reg  <= '0;
                second_reg <= '0;
                third_reg  <= '0;
            end
            else if (s2_item_reg.gray)
            begin
                first_reg  <= s2_luma_reg;
                second_reg <= '0;
                third_reg  <= '0;
            end
            else
            begin
                first_reg  <= s2_item_reg.red;
                second_reg <= s2_item_reg.green;
                third_reg  <= s2_item_reg.blue;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_offset  = offset_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;
    assign third_value  = third_reg;
    assign frame_end    = frame_end_reg;
    assign size_error   = size_error_reg;

endmodule

FILE: src/rgb_decimator_with_luma_unit.sv
// Integer-ratio decimator for a raster RGB pixel stream with optional luma output.
// Input channel (in_valid/in_ready, red/green/blue) takes one source pixel per
// request in raster order. Output channel (out_valid/out_ready) returns one request
// per kept pixel: its destination byte offset and either RGB or a single luma byte.
// With unusable sizes every input pixel returns one request with size_error set.
// Configuration: cfg_write with cfg_index and cfg_data writes one register; the user
// must write only while the unit is idle, which the block does not enforce. Reset
// and each write to a listed register restart the frame and re-derive the ratios,
// during which in_ready stays low (a 13-step shift-subtract divider per dimension).
// Throughput: one pixel per cycle while in_ready is high. A kept pixel passes the
// queue, the sum stage, the reciprocal multiply stage and the output register.
// A four-entry queue sits between the counter front end and the luma pipeline, so
// a stalled receiver fills the queue before in_ready drops; nothing is lost.
// Reset clears counters, queue and pipeline and loads the default register values.
module rgb_decimator_with_luma_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rgbdl_pkg::IDX_W-1:0]         cfg_index,
    input  logic [rgbdl_pkg::STRIDE_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rgbdl_pkg::PIX_W-1:0]         red,
    input  logic [rgbdl_pkg::PIX_W-1:0]         green,
    input  logic [rgbdl_pkg::PIX_W-1:0]         blue,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rgbdl_pkg::OFF_W-1:0]         byte_offset,
    output logic [rgbdl_pkg::PIX_W-1:0]         first_value,
    output logic [rgbdl_pkg::PIX_W-1:0]         second_value,
    output logic [rgbdl_pkg::PIX_W-1:0]         third_value,
    output logic                                frame_end,
    output logic                                size_error
);

    rgbdl_pkg::setup_t     setup;
    rgbdl_pkg::pix_item_t  push_item, head_item;
    logic                  push, pop, not_empty, q_full;

    // Register file and ratio derivation
    rgbdl_setup #(
        .MAX_DIM (MAX_DIM)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .setup     (setup)
    );

    // Counters and classification
    rgbdl_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .setup     (setup),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Decoupling queue
    rgbdl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty),
        .full      (q_full)
    );

    // Luma pipeline and output register
    rgbdl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .not_empty    (not_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_offset  (byte_offset),
        .first_value  (first_value),
        .second_value (second_value),
        .third_value  (third_value),
        .frame_end    (frame_end),
        .size_error   (size_error)
    );

endmodule
